/* rtl/tcc_pkg.sv */
// Shared types and constants for the text console cursor engine.
package tcc_pkg;

    localparam int MaxColumns = 256;
    localparam int MaxRows    = 128;

    localparam int ColW   = 9;   // cursor column, holds 0..MaxColumns
    localparam int RowW   = 7;   // cursor row, 0..MaxRows-1
    localparam int CfgColW = 9;
    localparam int CfgRowW = 8;
    localparam int CfgDataW = 9;
    localparam int CfgIdxW = 2;
    localparam int CharW  = 8;
    localparam int ColorW = 24;
    localparam int OutColW = 8;

    localparam logic [CfgColW-1:0] ColLimit = CfgColW'(MaxColumns);
    localparam logic [CfgRowW-1:0] RowLimit = CfgRowW'(MaxRows);

    localparam logic [CfgColW-1:0] ColumnsReset = 9'd80;
    localparam logic [CfgRowW-1:0] RowsReset    = 8'd25;

    localparam logic [CharW-1:0] ChNewline   = 8'd10;
    localparam logic [CharW-1:0] ChBackspace = 8'd8;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_COLUMNS = 2'd0,
        CFG_ROWS    = 2'd1,
        CFG_ENABLE  = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        OP_PUT   = 1'b0,
        OP_CLEAR = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        CMD_DRAW   = 2'd0,
        CMD_SCROLL = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [ColW-1:0] col;
        logic [RowW-1:0] row;
    } cursor_t;

    typedef struct packed {
        cmd_t               command;
        logic [CharW-1:0]   glyph;
        logic [OutColW-1:0] cell_column;
        logic [RowW-1:0]    cell_row;
        logic [ColorW-1:0]  draw_color;
        logic               last;
    } result_t;

    typedef struct packed {
        logic [CfgColW-1:0] columns;
        logic [CfgRowW-1:0] rows;
        logic               enable;
    } cfg_t;

    localparam result_t ResultBlank = '{
        command: CMD_DRAW, glyph: '0, cell_column: '0, cell_row: '0,
        draw_color: '0, last: 1'b0
    };

endpackage

/* rtl/tcc_step.sv */
// Cursor update and command generation for one input beat.
module tcc_step (
    input  tcc_pkg::cfg_t                  cfg,
    input  tcc_pkg::cursor_t               cur,
    input  logic                           opcode,
    input  logic [tcc_pkg::CharW-1:0]      char_code,
    input  logic [tcc_pkg::ColorW-1:0]     ink_color,
    output tcc_pkg::cursor_t               cur_next,
    output tcc_pkg::result_t               res0,
    output tcc_pkg::result_t               res1,
    output logic [1:0]                     res_cnt
);
    import tcc_pkg::*;

    logic [CfgColW-1:0] ncol;
    logic [CfgRowW-1:0] nrow;
    logic [CfgRowW-1:0] nrow_m1;
    logic [CfgColW-1:0] ncol_m1;
    logic [CfgRowW-1:0] row_inc;
    logic [RowW-1:0]    row_c;
    logic [ColW-1:0]    col1;
    logic [RowW-1:0]    row1;
    logic               wrap;
    logic               scroll;
    result_t            draw;
    result_t            scr;

    always_comb begin
        ncol = cfg.columns;
        if (cfg.columns == '0)
            ncol = CfgColW'(1);
        else if (cfg.columns > ColLimit)
            ncol = ColLimit;
        nrow = cfg.rows;
        if (cfg.rows == '0)
            nrow = CfgRowW'(1);
        else if (cfg.rows > RowLimit)
            nrow = RowLimit;
        nrow_m1 = nrow - CfgRowW'(1);
        ncol_m1 = ncol - CfgColW'(1);

        // rows may have been lowered under the cursor
        row_c = ({1'b0, cur.row} >= nrow) ? nrow_m1[RowW-1:0] : cur.row;

        wrap    = (char_code == ChNewline) || (cur.col >= ncol);
        row_inc = {1'b0, row_c} + CfgRowW'(1);
        scroll  = wrap && (row_inc >= nrow);
        col1    = cur.col;
        row1    = row_c;
        if (wrap) begin
            col1 = '0;
            if (!scroll)
                row1 = row_inc[RowW-1:0];
        end

        scr = ResultBlank;
        scr.command = CMD_SCROLL;

        draw = ResultBlank;
        draw.command     = CMD_DRAW;
        draw.glyph       = char_code;
        draw.cell_column = col1[OutColW-1:0];
        draw.cell_row    = row1;
        draw.draw_color  = ink_color;
        draw.last        = 1'b1;

        cur_next = cur;
        res0     = ResultBlank;
        res1     = ResultBlank;
        res_cnt  = 2'd0;

        if (cfg.enable) begin
            if (opcode == OP_CLEAR) begin
                cur_next     = '0;
                res0         = ResultBlank;
                res0.command = CMD_CLEAR;
                res0.last    = 1'b1;
                res_cnt      = 2'd1;
            end else if (char_code == ChNewline || char_code == ChBackspace) begin
                cur_next.col = col1;
                cur_next.row = row1;
                if (char_code == ChBackspace) begin
                    if (col1 != '0) begin
                        cur_next.col = col1 - ColW'(1);
                    end else if (row1 != '0) begin
                        cur_next.col = ncol_m1;
                        cur_next.row = row1 - RowW'(1);
                    end
                end
                res0      = scr;
                res0.last = 1'b1;
                res_cnt   = scroll ? 2'd1 : 2'd0;
            end else begin
                cur_next.col = col1 + ColW'(1);
                cur_next.row = row1;
                if (scroll) begin
                    res0    = scr;
                    res1    = draw;
                    res_cnt = 2'd2;
                end else begin
                    res0    = draw;
                    res_cnt = 2'd1;
                end
            end
        end
    end

endmodule

/* rtl/tcc_out_queue.sv */
// Four-entry result queue, takes up to two beats per cycle.
module tcc_out_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [1:0]        push_cnt,
    input  tcc_pkg::result_t  push0,
    input  tcc_pkg::result_t  push1,
    output logic              has_room,
    output logic              m_valid,
    input  logic              m_ready,
    output tcc_pkg::result_t  head
);
    import tcc_pkg::*;

    localparam int Depth = 4;
    localparam int PtrW  = $clog2(Depth);

    result_t         mem_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PtrW:0]   count_reg, count_next;
    logic            pop;
    logic [PtrW-1:0] wr_ptr_p1;

    assign m_valid   = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign pop       = m_valid && m_ready;
    // room for a two-beat item regardless of this cycle's pop
    assign has_room  = (count_reg <= (PtrW+1)'(Depth - 2));
    assign wr_ptr_p1 = wr_ptr_reg + PtrW'(1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PtrW'(push_cnt);
        rd_ptr_next = pop ? rd_ptr_reg + PtrW'(1) : rd_ptr_reg;
        count_next  = count_reg + (PtrW+1)'(push_cnt) - (PtrW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0)
            mem_reg[wr_ptr_reg] <= push0;
        if (push_cnt == 2'd2)
            mem_reg[wr_ptr_p1] <= push1;
    end

endmodule

/* rtl/text_console_cursor_engine.sv */
// Top level of the text console cursor engine.
//
//  channel  dir  handshake          payload
//  s_       in   s_valid/s_ready    opcode, char_code, ink_color
//  m_       out  m_valid/m_ready    command, glyph, cell_column, cell_row,
//                                   draw_color, last
//  cfg_     in   cfg_wr_en          cfg_index, cfg_wdata
//
// One input beat per cycle: a beat is registered in the input registers,
// then the cursor logic runs on it and its zero, one or two results go into a
// four-entry output queue, which sets the rate when m_ready is held low.
// A registered beat moves on only while the queue has two free slots.
// Reset clears the cursor to the top left cell and loads the default
// config (80 columns, 25 rows, enabled); no clearing pass is needed.
module text_console_cursor_engine (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_opcode,
    input  logic [tcc_pkg::CharW-1:0]       s_char_code,
    input  logic [tcc_pkg::ColorW-1:0]      s_ink_color,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_command,
    output logic [tcc_pkg::CharW-1:0]       m_glyph,
    output logic [tcc_pkg::OutColW-1:0]     m_cell_column,
    output logic [tcc_pkg::RowW-1:0]        m_cell_row,
    output logic [tcc_pkg::ColorW-1:0]      m_draw_color,
    output logic                            m_last,
    input  logic                            cfg_wr_en,
    input  logic [tcc_pkg::CfgIdxW-1:0]     cfg_index,
    input  logic [tcc_pkg::CfgDataW-1:0]    cfg_wdata
);
    import tcc_pkg::*;

    cfg_t               cfg_reg;
    cursor_t            cur_reg;
    cursor_t            cur_next;
    logic               in_vld_reg;
    logic               opcode_reg;
    logic [CharW-1:0]   char_reg;
    logic [ColorW-1:0]  color_reg;
    result_t            res0;
    result_t            res1;
    result_t            head;
    logic [1:0]         res_cnt;
    logic [1:0]         push_cnt;
    logic               has_room;
    logic               consume;

    assign consume  = in_vld_reg && has_room;
    assign s_ready  = !in_vld_reg || consume;
    assign push_cnt = consume ? res_cnt : 2'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.columns <= ColumnsReset;
            cfg_reg.rows    <= RowsReset;
            cfg_reg.enable  <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_COLUMNS: cfg_reg.columns <= cfg_wdata[CfgColW-1:0];
                CFG_ROWS:    cfg_reg.rows    <= cfg_wdata[CfgRowW-1:0];
                CFG_ENABLE:  cfg_reg.enable  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            cur_reg    <= '0;
        end else begin
            if (s_ready)
                in_vld_reg <= s_valid;
            if (consume)
                cur_reg <= cur_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            opcode_reg <= s_opcode;
            char_reg   <= s_char_code;
            color_reg  <= s_ink_color;
        end
    end

    tcc_step u_step (
        .cfg       (cfg_reg),
        .cur       (cur_reg),
        .opcode    (opcode_reg),
        .char_code (char_reg),
        .ink_color (color_reg),
        .cur_next  (cur_next),
        .res0      (res0),
        .res1      (res1),
        .res_cnt   (res_cnt)
    );

    tcc_out_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_cnt (push_cnt),
        .push0    (res0),
        .push1    (res1),
        .has_room (has_room),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .head     (head)
    );

    assign m_command     = head.command;
    assign m_glyph       = head.glyph;
    assign m_cell_column = head.cell_column;
    assign m_cell_row    = head.cell_row;
    assign m_draw_color  = head.draw_color;
    assign m_last        = head.last;

endmodule
